// ----- design/wmqi_pkg.sv -----
// Shared types, constants and arithmetic helpers of the wavetable morph interpolator.
package wmqi_pkg;

  localparam int TABLE_LENGTH_DEF = 1024;
  localparam int ROW_COUNT_DEF    = 16;

  localparam int POS_W  = 27;
  localparam int WORD_W = 15;
  localparam int OUT_W  = 12;
  localparam int ACC_W  = 28;

  localparam logic [20:0] SPLINE_SCALE = 21'd699051;
  localparam int          OUT_MAX      = 4095;

  localparam logic [1:0] CFG_SPAN_TWICE = 2'd0;
  localparam logic [1:0] CFG_SHIFT_R    = 2'd1;
  localparam logic [1:0] CFG_SHIFT_L    = 2'd2;

  localparam logic [26:0] SPAN_RST    = 27'd0;
  localparam logic [3:0]  SHIFT_R_RST = 4'd8;
  localparam logic [4:0]  SHIFT_L_RST = 5'd8;

  localparam logic [1:0] SLOPE_FLAT = 2'd0;
  localparam logic [1:0] SLOPE_RISE = 2'd1;
  localparam logic [1:0] SLOPE_FALL = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CALC = 1'b1;

  typedef struct packed {
    logic        func;
    logic        half;
    logic [3:0]  row_index;
    logic [9:0]  word_index;
    logic [14:0] table_word;
    logic [26:0] phase_position;
    logic [11:0] morph;
  } in_t;

  typedef struct packed {
    logic [11:0] sample_out;
    logic [1:0]  slope;
    logic        half_out;
  } out_t;

  // floor(f * x / 65536)
  function automatic logic signed [ACC_W-1:0] frac_mul(input logic [15:0] f,
                                                      input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W+16:0] prod;
    prod = $signed({1'b0, f}) * x;
    return prod[ACC_W+15:16];
  endfunction

endpackage

// ----- design/wmqi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wmqi_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/wavetable_morph_quintic_interpolator_unit.sv -----
// Top level: table load, morph crossfade and quintic spline sample pipeline.
// One beat is accepted per cycle whenever the result register is free or being taken;
// a load beat writes the table at acceptance and gives no result, a compute beat presents
// its result after stages A to I. The twelve table reads of a sample happen at once from
// twelve copies of the combined attack/release store, each written in parallel. in_stall
// is high only while a result waits and out_stall holds it. No clearing pass.
module wavetable_morph_quintic_interpolator_unit
  import wmqi_pkg::*;
#(
  parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
  parameter int ROW_COUNT    = ROW_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_wdata
);

  localparam int LW    = $clog2(TABLE_LENGTH);
  localparam int RW    = $clog2(ROW_COUNT);
  localparam int AW    = 1 + RW + LW;
  localparam int RSH   = 24;
  localparam int RECIP = ((1 << RSH) + TABLE_LENGTH - 1) / TABLE_LENGTH;

  typedef struct packed {
    logic        half;
    logic [1:0]  slope;
    logic [15:0] wf;
    logic [14:0] v2;
  } meta_t;

  logic [26:0] span_r;
  logic [3:0]  shr_r;
  logic [4:0]  shl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RST;
      shr_r  <= SHIFT_R_RST;
      shl_r  <= SHIFT_L_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPAN_TWICE: span_r <= cfg_wdata;
        CFG_SHIFT_R:    shr_r  <= cfg_wdata[3:0];
        CFG_SHIFT_L:    shl_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic adv, acc;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // stage A: position, rows, fraction
  logic [26:0] p;
  logic [11:0] fam, rem;
  logic [27:0] frac_w;
  logic [RW-1:0] lo_row, hi_row;

  always_comb begin
    p      = in_data.half ? (span_r - in_data.phase_position) : in_data.phase_position;
    fam    = in_data.morph >> shr_r;
    rem    = in_data.morph & ~(12'hFFF << shr_r);
    frac_w = 28'(rem) << shl_r;
    lo_row = (fam < 12'(ROW_COUNT - 1)) ? RW'(fam) : RW'(ROW_COUNT - 1);
    hi_row = (32'(lo_row) + 32'd1 < 32'(ROW_COUNT - 1)) ? RW'(lo_row + 1'b1)
                                                         : RW'(ROW_COUNT - 1);
  end

  logic          a_vld_r, a_half_r;
  logic [10:0]   a_base_r;
  logic [15:0]   a_wf_r, a_frac_r;
  logic [RW-1:0] a_lo_r, a_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid && in_data.func == FUNC_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_half_r <= in_data.half;
      a_base_r <= p[26:16];
      a_wf_r   <= p[15:0];
      a_frac_r <= frac_w[15:0];
      a_lo_r   <= lo_row;
      a_hi_r   <= hi_row;
    end
  end

  // table writes
  logic          wen;
  logic [AW-1:0] waddr;
  assign wen   = acc && in_data.func == FUNC_LOAD
                 && 32'(in_data.row_index) < ROW_COUNT
                 && 32'(in_data.word_index) < TABLE_LENGTH;
  assign waddr = {in_data.half, RW'(in_data.row_index), LW'(in_data.word_index)};

  // stage B: wrapped addresses and reads
  logic [31:0]   quo;
  logic [LW:0]   base_mod;
  logic [LW:0]   sk   [6];
  logic [LW-1:0] addr [6];

  always_comb begin
    quo      = (32'(a_base_r) * 32'(RECIP)) >> RSH;
    base_mod = (LW+1)'(32'(a_base_r) - quo * 32'(TABLE_LENGTH));
    for (int k = 0; k < 6; k++) begin
      sk[k]   = base_mod + (LW+1)'(k);
      addr[k] = (32'(sk[k]) >= TABLE_LENGTH) ? LW'(32'(sk[k]) - 32'(TABLE_LENGTH))
                                             : LW'(sk[k]);
    end
  end

  logic [14:0] rd_lo [6];
  logic [14:0] rd_hi [6];

  for (genvar k = 0; k < 6; k++) begin : g_lane
    wmqi_ram #(.WIDTH(WORD_W), .DEPTH(1 << AW)) u_lo (
      .clk(clk), .we(wen), .waddr(waddr), .wdata(in_data.table_word),
      .re(adv), .raddr({a_half_r, a_lo_r, addr[k]}), .rdata(rd_lo[k])
    );
    wmqi_ram #(.WIDTH(WORD_W), .DEPTH(1 << AW)) u_hi (
      .clk(clk), .we(wen), .waddr(waddr), .wdata(in_data.table_word),
      .re(adv), .raddr({a_half_r, a_hi_r, addr[k]}), .rdata(rd_hi[k])
    );
  end

  logic        b_vld_r, b_half_r;
  logic [15:0] b_wf_r, b_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_half_r <= a_half_r;
      b_wf_r   <= a_wf_r;
      b_frac_r <= a_frac_r;
    end
  end

  // stage C: crossfade
  logic signed [15:0] dif  [6];
  logic signed [32:0] lprd [6];
  logic signed [16:0] lsum [6];
  logic [14:0] v_nxt [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dif[k]   = $signed({1'b0, rd_hi[k]}) - $signed({1'b0, rd_lo[k]});
      lprd[k]  = dif[k] * $signed({1'b0, b_frac_r});
      lsum[k]  = $signed({2'b00, rd_lo[k]}) + lprd[k][32:16];
      v_nxt[k] = lsum[k][14:0];
    end
  end

  logic        c_vld_r, c_half_r;
  logic [15:0] c_wf_r;
  logic [14:0] c_v_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_half_r <= b_half_r;
      c_wf_r   <= b_wf_r;
      for (int k = 0; k < 6; k++) begin
        c_v_r[k] <= v_nxt[k];
      end
    end
  end

  // stage D: linear terms and slope
  logic signed [ACC_W-1:0] s [6];
  logic signed [ACC_W-1:0] c5_nxt, l4_nxt, l3_nxt, l2_nxt, l1_nxt;
  logic [1:0] slope_nxt;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      s[k] = $signed(ACC_W'(c_v_r[k]));
    end
    c5_nxt = (s[3] - s[2]) * 50 + (s[1] - s[4]) * 25 + (s[5] - s[0]) * 5;
    l4_nxt = s[2] * 126 - s[3] * 124 + s[4] * 61 - s[1] * 64 - s[5] * 12 + s[0] * 13;
    l3_nxt = s[3] * 66 - s[2] * 70 - s[4] * 33 + s[1] * 39 + s[5] * 7 - s[0] * 9;
    l2_nxt = (s[3] + s[1]) * 16 - s[0] - s[2] * 30 - s[4];
    l1_nxt = (s[3] - s[1]) * 16 + (s[0] - s[4]) * 2;
    if (!c_half_r) begin
      if (c_v_r[2] < c_v_r[3])      slope_nxt = SLOPE_RISE;
      else if (c_v_r[1] < c_v_r[2]) slope_nxt = SLOPE_FALL;
      else                          slope_nxt = SLOPE_FLAT;
    end else begin
      if (c_v_r[1] < c_v_r[2])      slope_nxt = SLOPE_RISE;
      else if (c_v_r[2] < c_v_r[3]) slope_nxt = SLOPE_FALL;
      else                          slope_nxt = SLOPE_FLAT;
    end
  end

  logic d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r;
  meta_t d_m_r, e_m_r, f_m_r, g_m_r, h_m_r, i_m_r;
  logic signed [ACC_W-1:0] d_c5_r, d_l4_r, d_l3_r, d_l2_r, d_l1_r;
  logic signed [ACC_W-1:0] e_c4_r, e_l3_r, e_l2_r, e_l1_r;
  logic signed [ACC_W-1:0] f_c3_r, f_l2_r, f_l1_r;
  logic signed [ACC_W-1:0] g_c2_r, g_l1_r;
  logic signed [ACC_W-1:0] h_c1_r;
  logic signed [48:0]      i_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= f_vld_r;
      h_vld_r   <= g_vld_r;
      i_vld_r   <= h_vld_r;
      out_valid <= i_vld_r;
    end
  end

  // Horner chain, one step per stage
  logic signed [ACC_W-1:0] y;
  logic signed [ACC_W-1:0] o;
  logic [11:0] o_clamp;

  always_comb begin
    y = $signed(ACC_W'(i_m_r.v2)) + ACC_W'($signed(i_t_r[48:24]));
    o = y >>> 3;
    if (o < 0)                  o_clamp = '0;
    else if (o > ACC_W'(OUT_MAX)) o_clamp = OUT_W'(OUT_MAX);
    else                        o_clamp = o[11:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_m_r  <= '{half: c_half_r, slope: slope_nxt, wf: c_wf_r, v2: c_v_r[2]};
      d_c5_r <= c5_nxt;
      d_l4_r <= l4_nxt;
      d_l3_r <= l3_nxt;
      d_l2_r <= l2_nxt;
      d_l1_r <= l1_nxt;

      e_m_r  <= d_m_r;
      e_c4_r <= d_l4_r + frac_mul(d_m_r.wf, d_c5_r);
      e_l3_r <= d_l3_r;
      e_l2_r <= d_l2_r;
      e_l1_r <= d_l1_r;

      f_m_r  <= e_m_r;
      f_c3_r <= e_l3_r + frac_mul(e_m_r.wf, e_c4_r);
      f_l2_r <= e_l2_r;
      f_l1_r <= e_l1_r;

      g_m_r  <= f_m_r;
      g_c2_r <= f_l2_r + frac_mul(f_m_r.wf, f_c3_r);
      g_l1_r <= f_l1_r;

      h_m_r  <= g_m_r;
      h_c1_r <= g_l1_r + frac_mul(g_m_r.wf, g_c2_r);

      i_m_r  <= h_m_r;
      i_t_r  <= $signed({1'b0, SPLINE_SCALE}) * frac_mul(h_m_r.wf, h_c1_r);

      out_data <= '{sample_out: o_clamp, slope: i_m_r.slope, half_out: i_m_r.half};
    end
  end

endmodule

// ----- design/wmqi_chk.sv -----
// Port-level checker for the interpolator top level, with its bind.
module wmqi_chk
  import wmqi_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input out_t out_data,
  input logic out_valid,
  input logic out_stall
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_slope: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slope != 2'd3)
    else $error("bad slope code");

  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wavetable_morph_quintic_interpolator_unit wmqi_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
